/* rtl/core/vcfb_pkg.sv */
// Package for the valve command frame builder.
// Holds item and frame types, command codes and the BCD/clamp helpers.
// No dependencies.
package vcfb_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned IDX_W       = 3;

  typedef enum logic [1:0] {
    OP_READ_STATUS = 2'd0,
    OP_SET_ROOM    = 2'd1,
    OP_SET_RANGE   = 2'd2,
    OP_FORCE_VALVE = 2'd3
  } opcode_t;

  localparam logic [7:0] CODE_READ_STATUS = 8'ha0;
  localparam logic [7:0] CODE_SET_ROOM    = 8'ha9;
  localparam logic [7:0] CODE_SET_RANGE   = 8'ha6;
  localparam logic [7:0] CODE_FORCE_VALVE = 8'ha3;

  localparam logic [7:0] VALVE_CLOSE_REQ  = 8'h99;
  localparam logic [7:0] VALVE_OPEN_REQ   = 8'h55;
  localparam logic [7:0] VALVE_CLOSE_CODE = 8'h02;
  localparam logic [7:0] VALVE_OPEN_CODE  = 8'h04;

  localparam logic [7:0] ROOM_MIN  = 8'd5;
  localparam logic [7:0] ROOM_MAX  = 8'd30;
  localparam logic [7:0] UPPER_MIN = 8'd35;
  localparam logic [7:0] UPPER_MAX = 8'd70;
  localparam logic [7:0] LOWER_MIN = 8'd5;
  localparam logic [7:0] LOWER_MAX = 8'd10;

  localparam logic [7:0] CSUM_MASK = 8'hA5;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] addr_lo;
    logic [7:0] addr_hi;
    logic [7:0] data_a;
    logic [7:0] data_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last_byte;
  } out_item_t;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  // high nibble * 10 + low nibble, 0..165
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0000, b[7:4]};
    lo = {4'b0000, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  function automatic logic [7:0] clamp_u8(input logic [7:0] v, input logic [7:0] lo,
                                          input logic [7:0] hi);
    logic [7:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/core/vcfb_front.sv */
// Front end: accepts commands and builds the complete 8-byte frame.
// Writes built frames into the frame queue. Depends on vcfb_pkg.
module vcfb_front (
  input  logic               in_push,
  input  vcfb_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_wr,
  output vcfb_pkg::frame_t   q_wr_data
);

  logic [7:0] code;
  logic [7:0] b3;
  logic [7:0] b4;
  logic [7:0] b5;
  logic [7:0] b6;
  logic [7:0] sum;

  assign q_wr = in_push && !q_full;

  always_comb begin
    code = vcfb_pkg::CODE_READ_STATUS;
    b3   = 8'h00;
    b4   = 8'h00;
    b5   = 8'h00;
    b6   = 8'h00;
    case (in_data.opcode)
      vcfb_pkg::OP_READ_STATUS: begin
        code = vcfb_pkg::CODE_READ_STATUS;
      end
      vcfb_pkg::OP_SET_ROOM: begin
        code = vcfb_pkg::CODE_SET_ROOM;
        b6   = vcfb_pkg::clamp_u8(vcfb_pkg::bcd_to_bin(in_data.data_a),
                                  vcfb_pkg::ROOM_MIN, vcfb_pkg::ROOM_MAX);
      end
      vcfb_pkg::OP_SET_RANGE: begin
        code = vcfb_pkg::CODE_SET_RANGE;
        b5   = vcfb_pkg::clamp_u8(vcfb_pkg::bcd_to_bin(in_data.data_a),
                                  vcfb_pkg::UPPER_MIN, vcfb_pkg::UPPER_MAX);
        b4   = vcfb_pkg::clamp_u8(vcfb_pkg::bcd_to_bin(in_data.data_b),
                                  vcfb_pkg::LOWER_MIN, vcfb_pkg::LOWER_MAX);
      end
      vcfb_pkg::OP_FORCE_VALVE: begin
        code = vcfb_pkg::CODE_FORCE_VALVE;
        if (in_data.data_a == vcfb_pkg::VALVE_CLOSE_REQ) begin
          b3 = vcfb_pkg::VALVE_CLOSE_CODE;
        end else if (in_data.data_a == vcfb_pkg::VALVE_OPEN_REQ) begin
          b3 = vcfb_pkg::VALVE_OPEN_CODE;
        end else begin
          b3 = 8'h00;
        end
      end
      default: begin
        code = vcfb_pkg::CODE_READ_STATUS;
      end
    endcase
  end

  assign sum = code + in_data.addr_lo + in_data.addr_hi + b3 + b4 + b5 + b6;

  always_comb begin
    q_wr_data    = '0;
    q_wr_data[0] = code;
    q_wr_data[1] = in_data.addr_lo;
    q_wr_data[2] = in_data.addr_hi;
    q_wr_data[3] = b3;
    q_wr_data[4] = b4;
    q_wr_data[5] = b5;
    q_wr_data[6] = b6;
    q_wr_data[7] = sum ^ vcfb_pkg::CSUM_MASK;
  end

endmodule

/* rtl/core/vcfb_fifo.sv */
// Short frame queue between the front end and the byte serializer.
// Register array with read/write pointers and an occupancy count. Depends on vcfb_pkg.
module vcfb_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  vcfb_pkg::frame_t wr_data,
  output logic             full,
  input  logic             rd,
  output vcfb_pkg::frame_t rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);

  vcfb_pkg::frame_t slots_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == LAST_SLOT) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == LAST_SLOT) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("frame queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (count_r == $past(count_r) + 1'b1))
    else $error("frame queue count missed a write");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (wptr_r == rptr_r))
    else $error("frame queue empty with pointers apart");

endmodule

/* rtl/core/vcfb_back.sv */
// Byte serializer: takes frames from the queue and sends them one byte per transfer.
// Output register decouples the result side. Depends on vcfb_pkg.
module vcfb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  vcfb_pkg::frame_t    q_rd_data,
  output logic                q_rd,
  output logic                out_empty,
  input  logic                out_pop,
  output vcfb_pkg::out_item_t out_data
);

  localparam logic [vcfb_pkg::IDX_W-1:0] LAST_IDX = vcfb_pkg::IDX_W'(vcfb_pkg::FRAME_BYTES - 1);

  vcfb_pkg::frame_t              frame_r, frame_nxt;
  logic [vcfb_pkg::IDX_W-1:0]    pos_r, pos_nxt;
  logic                          busy_r, busy_nxt;
  logic                          oval_r, oval_nxt;
  vcfb_pkg::out_item_t           odata_r, odata_nxt;
  vcfb_pkg::frame_t              src;
  logic                          can_load;
  logic                          have;
  logic                          load;

  assign can_load = !oval_r || out_pop;
  assign have     = busy_r || !q_empty;
  assign load     = can_load && have;
  assign src      = busy_r ? frame_r : q_rd_data;
  assign q_rd     = load && !busy_r;

  always_comb begin
    frame_nxt = frame_r;
    pos_nxt   = pos_r;
    busy_nxt  = busy_r;
    oval_nxt  = oval_r;
    odata_nxt = odata_r;
    if (out_pop && oval_r) begin
      oval_nxt = 1'b0;
    end
    if (load) begin
      if (!busy_r) begin
        frame_nxt = q_rd_data;
      end
      odata_nxt.frame_byte = src[pos_r];
      odata_nxt.byte_index = pos_r;
      odata_nxt.last_byte  = (pos_r == LAST_IDX);
      oval_nxt             = 1'b1;
      pos_nxt              = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
      busy_nxt             = (pos_r != LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      busy_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    odata_r <= odata_nxt;
  end

  assign out_empty = !oval_r;
  assign out_data  = odata_r;

  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pos_r != '0))
    else $error("serializer busy at frame start");

  a_idx_follow: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (oval_r && odata_r.byte_index == $past(pos_r)))
    else $error("sent byte index does not match position");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r |-> (odata_r.last_byte == (odata_r.byte_index == LAST_IDX)))
    else $error("last byte flag out of place");

  a_no_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> (!q_empty && pos_r == '0))
    else $error("frame taken mid-frame or from empty queue");

endmodule

/* rtl/core/valve_command_frame_builder_core.sv */
// A command accepted into the frame queue reaches out_data through a queue slot and the serializer output register.
// The byte serializer sends one frame byte per cycle while out_pop drains its output register.
// Up to QUEUE_DEPTH built frames wait between front end and serializer, so in_full
// rises only when the queue holds QUEUE_DEPTH frames.
// Reset (rst_n low, synchronous): queue pointers, serializer position and output valid clear.
module valve_command_frame_builder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  vcfb_pkg::in_item_t  in_data,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output vcfb_pkg::out_item_t out_data
);

  logic             q_wr;
  vcfb_pkg::frame_t q_wr_data;
  logic             q_full;
  logic             q_rd;
  vcfb_pkg::frame_t q_rd_data;
  logic             q_empty;

  assign in_full = q_full;

  vcfb_front u_front (
    .in_push   (in_push),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_data (q_wr_data)
  );

  vcfb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  vcfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rd_data (q_rd_data),
    .q_rd      (q_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
